// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/b3iou_pkg.sv =====
package b3iou_pkg;

  localparam int FIELD_W = 16;
  localparam int RATIO_W = 17;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  typedef enum logic [1:0] {
    ST_OVERLAP     = 2'd0,
    ST_DISJOINT    = 2'd1,
    ST_EMPTY_UNION = 2'd2
  } status_e;

endpackage

// ===== sv/b3iou_div.sv =====
module b3iou_div
  import b3iou_pkg::*;
#(
  parameter int NUM_W     = 48,
  parameter int DEN_W     = 49,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  input  logic               disjoint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RATIO_W-1:0] ratio_o,
  output status_e            status_o
);

  localparam int DEPTH = FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int SW    = (QW > RATIO_W) ? QW : RATIO_W;

  logic [DEPTH-1:0] v_q;
  logic [DEN_W-1:0] r_d [DEPTH];
  logic [DEN_W-1:0] r_q [DEPTH];
  logic [DEN_W-1:0] den_d [DEPTH];
  logic [DEN_W-1:0] den_q [DEPTH];
  logic [QW-1:0]    q_d [DEPTH];
  logic [QW-1:0]    q_q [DEPTH];
  status_e          st_d [DEPTH];
  status_e          st_q [DEPTH];
  logic             en;

  // The whole divider advances together; only the front stages fill gaps while it is held.
  assign en         = !v_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  // First step: the quotient's integer bit, set only when the two volumes match.
  // After it, one restoring step per stage for each fraction bit.
  always_comb begin
    logic [DEN_W-1:0] nx;
    logic             ge0;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    nx       = DEN_W'(num_i);
    ge0      = (nx >= den_i);
    r_d[0]   = ge0 ? (nx - den_i) : nx;
    q_d[0]   = QW'(ge0);
    den_d[0] = den_i;
    if (disjoint_i) begin
      st_d[0] = ST_DISJOINT;
    end else if (den_i == '0) begin
      st_d[0] = ST_EMPTY_UNION;
    end else begin
      st_d[0] = ST_OVERLAP;
    end
    for (int j = 1; j < DEPTH; j++) begin
      sh       = {r_q[j-1], 1'b0};
      diff     = sh - {1'b0, den_q[j-1]};
      ge       = (sh >= {1'b0, den_q[j-1]});
      r_d[j]   = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      q_d[j]   = {q_q[j-1][QW-2:0], ge};
      den_d[j] = den_q[j-1];
      st_d[j]  = st_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DEPTH; j++) begin
        r_q[j]   <= r_d[j];
        den_q[j] <= den_d[j];
        q_q[j]   <= q_d[j];
        st_q[j]  <= st_d[j];
      end
    end
  end

  logic [SW-1:0]      q_ext;
  logic [RATIO_W-1:0] q_sat;

  // The quotient never exceeds one; clamp only matters when one does not fit.
  assign q_ext       = SW'(q_q[DEPTH-1]);
  assign q_sat       = (q_ext > SW'(RATIO_MAX)) ? RATIO_MAX : q_ext[RATIO_W-1:0];
  assign out_valid_o = v_q[DEPTH-1];
  assign status_o    = st_q[DEPTH-1];
  assign ratio_o     = (st_q[DEPTH-1] != ST_OVERLAP) ? '0 : q_sat;

endmodule

// ===== sv/box3d_intersection_over_union.sv =====
// Intersection over union of two axis-aligned 3D boxes.
// Input channel: in_valid_i / in_ready_o with twelve signed coordinates, the
// low and high bound of box A and box B on x, y and z. Output channel:
// out_valid_o / out_ready_i with overlap_ratio_o (unsigned, RATIO_FRAC_BITS
// fraction bits, 1.0 at most) and status_o (overlap, disjoint, empty union).
// Each item gives exactly one result, in order.
// Five stages form extents, volumes and the union, then the restoring
// divider takes one stage per quotient bit. One item can enter every cycle
// while the receiver does not stall, so throughput is one item per cycle;
// the divider's per-bit stages set the depth.
// Reset empties every stage; no result is pending afterwards.
// When the receiver stalls, the divider holds all of its stages, items and
// gaps alike, while the five front stages keep filling their empty slots, so
// in_ready_o drops once those five stages are full.
module box3d_intersection_over_union
  import b3iou_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FIELD_W-1:0] a_x_low_i,
  input  logic [FIELD_W-1:0] a_x_high_i,
  input  logic [FIELD_W-1:0] a_y_low_i,
  input  logic [FIELD_W-1:0] a_y_high_i,
  input  logic [FIELD_W-1:0] a_z_low_i,
  input  logic [FIELD_W-1:0] a_z_high_i,
  input  logic [FIELD_W-1:0] b_x_low_i,
  input  logic [FIELD_W-1:0] b_x_high_i,
  input  logic [FIELD_W-1:0] b_y_low_i,
  input  logic [FIELD_W-1:0] b_y_high_i,
  input  logic [FIELD_W-1:0] b_z_low_i,
  input  logic [FIELD_W-1:0] b_z_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RATIO_W-1:0] overlap_ratio_o,
  output logic [1:0]         status_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int EXT_W  = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int PROD_W = 2 * CW;
  localparam int VOL_W  = 3 * CW;
  localparam int UN_W   = 3 * CW + 1;
  localparam int BOX_A  = 0;
  localparam int BOX_B  = 1;
  localparam int BOX_I  = 2;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic div_ready;

  // Each stage moves on when it is empty or the next one moves.
  assign en5        = !v5_q || div_ready;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: coordinates, intersection bounds and extents.
  logic [FIELD_W-1:0]   raw [12];
  logic [EXT_W-1:0]     ext [12];
  logic signed [CW-1:0] crd [12];
  logic [CW-1:0]        extent_d [3][3];
  logic [CW-1:0]        extent_q [3][3];
  logic                 dis1_d, dis1_q;

  assign raw[0]  = a_x_low_i;
  assign raw[1]  = a_x_high_i;
  assign raw[2]  = a_y_low_i;
  assign raw[3]  = a_y_high_i;
  assign raw[4]  = a_z_low_i;
  assign raw[5]  = a_z_high_i;
  assign raw[6]  = b_x_low_i;
  assign raw[7]  = b_x_high_i;
  assign raw[8]  = b_y_low_i;
  assign raw[9]  = b_y_high_i;
  assign raw[10] = b_z_low_i;
  assign raw[11] = b_z_high_i;

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      ext[k] = EXT_W'(raw[k]);
      crd[k] = ext[k][CW-1:0];
    end
  end

  always_comb begin
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    dis1_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      extent_d[BOX_A][k] = (crd[2*k+1] < crd[2*k]) ? '0 : $unsigned(crd[2*k+1] - crd[2*k]);
      extent_d[BOX_B][k] = (crd[2*k+7] < crd[2*k+6]) ? '0 :
                           $unsigned(crd[2*k+7] - crd[2*k+6]);
      lo = (crd[2*k] > crd[2*k+6]) ? crd[2*k] : crd[2*k+6];
      hi = (crd[2*k+1] < crd[2*k+7]) ? crd[2*k+1] : crd[2*k+7];
      // The intersection extent is only used when no axis is empty.
      extent_d[BOX_I][k] = $unsigned(hi - lo);
      if (hi < lo) begin
        dis1_d = 1'b1;
      end
    end
  end

  // Stage 2: x by y areas.  Stage 3: area by z, split in two halves.  Stage 4: volumes.  Stage 5: union.
  logic [PROD_W-1:0] area_q [3];
  logic [CW-1:0]     z2_q [3];
  logic              dis2_q;
  logic [PROD_W-1:0] plo_q [3];
  logic [PROD_W-1:0] phi_q [3];
  logic              dis3_q;
  logic [VOL_W-1:0]  vol_q [3];
  logic              dis4_q;
  logic [VOL_W-1:0]  num5_q;
  logic [UN_W-1:0]   un5_q;
  logic              dis5_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      extent_q <= extent_d;
      dis1_q   <= dis1_d;
    end
    if (en2) begin
      for (int b = 0; b < 3; b++) begin
        area_q[b] <= PROD_W'(extent_q[b][0]) * PROD_W'(extent_q[b][1]);
        z2_q[b]   <= extent_q[b][2];
      end
      dis2_q <= dis1_q;
    end
    if (en3) begin
      for (int b = 0; b < 3; b++) begin
        plo_q[b] <= PROD_W'(area_q[b][CW-1:0]) * PROD_W'(z2_q[b]);
        phi_q[b] <= PROD_W'(area_q[b][PROD_W-1:CW]) * PROD_W'(z2_q[b]);
      end
      dis3_q <= dis2_q;
    end
    if (en4) begin
      for (int b = 0; b < 3; b++) begin
        vol_q[b] <= VOL_W'(plo_q[b]) + (VOL_W'(phi_q[b]) << CW);
      end
      dis4_q <= dis3_q;
    end
    if (en5) begin
      // A real intersection lies inside both boxes, so this cannot wrap.
      un5_q  <= UN_W'(vol_q[BOX_A]) + UN_W'(vol_q[BOX_B]) - UN_W'(vol_q[BOX_I]);
      num5_q <= vol_q[BOX_I];
      dis5_q <= dis4_q;
    end
  end

  status_e div_status;

  b3iou_div #(
    .NUM_W     (VOL_W),
    .DEN_W     (UN_W),
    .FRAC_BITS (RATIO_FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (div_ready),
    .num_i       (num5_q),
    .den_i       (un5_q),
    .disjoint_i  (dis5_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ratio_o     (overlap_ratio_o),
    .status_o    (div_status)
  );

  assign status_o = div_status;

endmodule

// ===== sv/b3iou_checker.sv =====
`include "assert_macros.svh"

module b3iou_checker
  import b3iou_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [RATIO_W-1:0] overlap_ratio_o,
  input logic [1:0]         status_o
);

  localparam logic [RATIO_W-1:0] RATIO_CAP =
    (RATIO_FRAC_BITS >= RATIO_W) ? RATIO_MAX : RATIO_W'(1 << RATIO_FRAC_BITS);

  // A stalled result stays offered and unchanged.
  `ASSERT_CLKD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_ratio_o) && $stable(status_o), "stalled result changed")

  // Input back-pressure only arises from a stalled result.
  `ASSERT_ALWAYS(a_ready_cause, !in_ready_o |-> out_valid_o && !out_ready_i, "input blocked without a stalled result")

  // Disjoint and empty-union results carry a zero ratio.
  `ASSERT_CLKD(a_ratio_zero, out_valid_o && status_o != ST_OVERLAP |-> overlap_ratio_o == '0, "nonzero ratio without overlap")

  // The ratio never exceeds one.
  `ASSERT_CLKD(a_ratio_cap, out_valid_o |-> overlap_ratio_o <= RATIO_CAP, "ratio above one")

endmodule

bind box3d_intersection_over_union b3iou_checker #(
  .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_checker (.*);

// ===== tb/tb_box3d_intersection_over_union.sv =====
module tb_box3d_intersection_over_union;
  timeunit 1ns;
  timeprecision 1ps;

  import b3iou_pkg::*;

  localparam int COORD_WIDTH     = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  // Index 0 is x, 1 is y and 2 is z.
  typedef struct packed {
    logic [2:0][FIELD_W-1:0] a_lo;
    logic [2:0][FIELD_W-1:0] a_hi;
    logic [2:0][FIELD_W-1:0] b_lo;
    logic [2:0][FIELD_W-1:0] b_hi;
  } box_pair_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    status_e            status;
  } iou_result_t;

  class iou_scoreboard;
    iou_result_t expected_iou_q[$];
    int errors;
    int checked;
    int n_overlap;
    int n_disjoint;
    int n_empty;
    int n_full;

    function new();
      errors     = 0;
      checked    = 0;
      n_overlap  = 0;
      n_disjoint = 0;
      n_empty    = 0;
      n_full     = 0;
    endfunction

    function logic [63:0] axis_extent(logic signed [FIELD_W-1:0] lo,
                                      logic signed [FIELD_W-1:0] hi);
      if (hi < lo) return '0;
      return 64'(int'(hi) - int'(lo));
    endfunction

    function iou_result_t predict_iou(box_pair_t p);
      logic signed [FIELD_W-1:0] lo, hi;
      logic [63:0] vol_a, vol_b, vol_i, vol_u;
      logic [95:0] quot, one;
      iou_result_t r;
      int k;
      r.ratio  = '0;
      r.status = ST_OVERLAP;
      vol_a = 64'd1;
      vol_b = 64'd1;
      vol_i = 64'd1;
      one   = 96'd1 << RATIO_FRAC_BITS;
      for (k = 0; k < 3; k++) begin
        lo = ($signed(p.a_lo[k]) > $signed(p.b_lo[k])) ? p.a_lo[k] : p.b_lo[k];
        hi = ($signed(p.a_hi[k]) < $signed(p.b_hi[k])) ? p.a_hi[k] : p.b_hi[k];
        if (hi < lo) begin
          r.status = ST_DISJOINT;
          return r;
        end
        vol_a = vol_a * axis_extent(p.a_lo[k], p.a_hi[k]);
        vol_b = vol_b * axis_extent(p.b_lo[k], p.b_hi[k]);
        vol_i = vol_i * axis_extent(lo, hi);
      end
      vol_u = vol_a + (vol_b - vol_i);
      if (vol_u == 64'd0) begin
        r.status = ST_EMPTY_UNION;
        return r;
      end
      quot = (96'(vol_i) << RATIO_FRAC_BITS) / 96'(vol_u);
      if (quot > one) quot = one;
      if (quot > 96'(RATIO_MAX)) quot = 96'(RATIO_MAX);
      r.ratio = quot[RATIO_W-1:0];
      return r;
    endfunction

    function void note_pair(box_pair_t p);
      expected_iou_q.push_back(predict_iou(p));
    endfunction

    function void check_result(logic [RATIO_W-1:0] ratio, logic [1:0] status);
      iou_result_t exp_r;
      if (expected_iou_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result ratio=%0d status=%0d with no item pending",
                   ratio, status);
        return;
      end
      exp_r = expected_iou_q.pop_front();
      checked++;
      case (exp_r.status)
        ST_DISJOINT:    n_disjoint++;
        ST_EMPTY_UNION: n_empty++;
        default: begin
          n_overlap++;
          if (exp_r.ratio == RATIO_W'(1 << RATIO_FRAC_BITS)) n_full++;
        end
      endcase
      if (ratio !== exp_r.ratio || status !== exp_r.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: ratio exp %0d got %0d, status exp %s got %0d",
                   checked, exp_r.ratio, ratio, exp_r.status.name(), status);
      end
    endfunction

    function int pending();
      return expected_iou_q.size();
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [FIELD_W-1:0] a_x_low_i   = '0;
  logic [FIELD_W-1:0] a_x_high_i  = '0;
  logic [FIELD_W-1:0] a_y_low_i   = '0;
  logic [FIELD_W-1:0] a_y_high_i  = '0;
  logic [FIELD_W-1:0] a_z_low_i   = '0;
  logic [FIELD_W-1:0] a_z_high_i  = '0;
  logic [FIELD_W-1:0] b_x_low_i   = '0;
  logic [FIELD_W-1:0] b_x_high_i  = '0;
  logic [FIELD_W-1:0] b_y_low_i   = '0;
  logic [FIELD_W-1:0] b_y_high_i  = '0;
  logic [FIELD_W-1:0] b_z_low_i   = '0;
  logic [FIELD_W-1:0] b_z_high_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [RATIO_W-1:0] overlap_ratio_o;
  logic [1:0]         status_o;

  iou_scoreboard iou_sb = new();
  int send_idle_pct = 22;
  int recv_idle_pct = 49;
  int pairs_sent    = 0;
  int quiet_cycles  = 0;

  box3d_intersection_over_union #(
    .COORD_WIDTH    (COORD_WIDTH),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .a_x_low_i      (a_x_low_i),
    .a_x_high_i     (a_x_high_i),
    .a_y_low_i      (a_y_low_i),
    .a_y_high_i     (a_y_high_i),
    .a_z_low_i      (a_z_low_i),
    .a_z_high_i     (a_z_high_i),
    .b_x_low_i      (b_x_low_i),
    .b_x_high_i     (b_x_high_i),
    .b_y_low_i      (b_y_low_i),
    .b_y_high_i     (b_y_high_i),
    .b_z_low_i      (b_z_low_i),
    .b_z_high_i     (b_z_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .overlap_ratio_o(overlap_ratio_o),
    .status_o       (status_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are checked here; the watchdog ends the run if neither channel
  // moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) iou_sb.check_result(overlap_ratio_o, status_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic box_pair_t make_pair(int ax0, int ax1, int ay0, int ay1, int az0, int az1,
                                          int bx0, int bx1, int by0, int by1, int bz0,
                                          int bz1);
    box_pair_t p;
    p.a_lo = {16'(az0), 16'(ay0), 16'(ax0)};
    p.a_hi = {16'(az1), 16'(ay1), 16'(ax1)};
    p.b_lo = {16'(bz0), 16'(by0), 16'(bx0)};
    p.b_hi = {16'(bz1), 16'(by1), 16'(bx1)};
    return p;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int rand_signed(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  // Mostly well-formed boxes, with B placed near A so that overlaps are
  // common; a share of pairs are raw bit patterns, identical or inverted.
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind, mag, alo, ahi, blo, bhi, tmp, k;
    kind = $urandom_range(99);
    if (kind < 12) begin
      p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return p;
    end
    for (k = 0; k < 3; k++) begin
      mag = ($urandom_range(1) == 0) ? 48 : 32768;
      alo = clamp_coord(rand_signed(mag));
      ahi = clamp_coord(alo + (($urandom_range(19) == 0) ? 0 : int'($urandom_range(mag))));
      if ($urandom_range(9) < 7) blo = clamp_coord(alo + rand_signed((ahi - alo) / 2 + 1));
      else blo = clamp_coord(rand_signed(mag));
      bhi = clamp_coord(blo + (($urandom_range(19) == 0) ? 0 : int'($urandom_range(mag))));
      if (kind < 20) begin
        blo = alo;
        bhi = ahi;
      end
      if ($urandom_range(29) == 0) begin
        tmp = alo;
        alo = ahi;
        ahi = tmp;
      end
      p.a_lo[k] = 16'(alo);
      p.a_hi[k] = 16'(ahi);
      p.b_lo[k] = 16'(blo);
      p.b_hi[k] = 16'(bhi);
    end
    return p;
  endfunction

  // Entered in the time step of a rising edge; returns in the time step of
  // the edge at which the item was taken.
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_x_low_i  <= p.a_lo[0];
    a_x_high_i <= p.a_hi[0];
    a_y_low_i  <= p.a_lo[1];
    a_y_high_i <= p.a_hi[1];
    a_z_low_i  <= p.a_lo[2];
    a_z_high_i <= p.a_hi[2];
    b_x_low_i  <= p.b_lo[0];
    b_x_high_i <= p.b_hi[0];
    b_y_low_i  <= p.b_lo[1];
    b_y_high_i <= p.b_hi[1];
    b_z_low_i  <= p.b_lo[2];
    b_z_high_i <= p.b_hi[2];
    do @(posedge clk_i); while (!in_ready_o);
    iou_sb.note_pair(p);
    pairs_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identical boxes, full range and unit size.
    send_pair(make_pair(-32768, 32767, -32768, 32767, -32768, 32767,
                        -32768, 32767, -32768, 32767, -32768, 32767));
    send_pair(make_pair(0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1));
    // Separated on x, then on z only.
    send_pair(make_pair(0, 10, 0, 10, 0, 10, 11, 20, 0, 10, 0, 10));
    send_pair(make_pair(0, 10, 0, 10, -5, -1, 0, 10, 0, 10, 0, 10));
    // Boxes touching on one face give a zero intersection volume.
    send_pair(make_pair(0, 10, 0, 10, 0, 10, 10, 20, 0, 10, 0, 10));
    // Every extent zero: the union is empty.
    send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    // Flat boxes in the same plane also have an empty union.
    send_pair(make_pair(0, 0, 0, 5, 0, 5, 0, 0, 0, 5, 0, 5));
    // A point inside a solid box.
    send_pair(make_pair(3, 3, 3, 3, 3, 3, 0, 10, 0, 10, 0, 10));
    // Inverted boxes, one and then both.
    send_pair(make_pair(10, 0, 0, 10, 0, 10, -20, 20, -20, 20, -20, 20));
    send_pair(make_pair(10, 0, 10, 0, 10, 0, 10, 0, 10, 0, 10, 0));
    // Containment and partial overlap.
    send_pair(make_pair(0, 100, 0, 100, 0, 100, 25, 75, 25, 75, 25, 75));
    send_pair(make_pair(0, 2, 0, 1, 0, 1, 1, 3, 0, 1, 0, 1));
    send_pair(make_pair(-32768, 32767, -32768, 32767, -32768, 32767,
                        -32768, 0, -32768, 32767, -32768, 32767));
    // Corners of the coordinate range, then all-negative boxes and bit patterns.
    send_pair(make_pair(-32768, 32767, -32768, 32767, -32768, 32767,
                        32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, 32767, -32768, 32767, -32768, 32767));
    send_pair(make_pair(-300, -100, -250, -50, -20, -1, -200, -10, -100, 0, -30, -5));
    send_pair(make_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'h8001, 16'h7FFE, 16'h8001, 16'h7FFE, 16'h8001, 16'h7FFE));
    send_pair(make_pair(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_random(320);

    send_idle_pct = 49;
    recv_idle_pct = 22;
    send_random(320);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(310);
    in_valid_i <= 1'b0;

    while (iou_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d box pairs sent, %0d results checked, %0d mismatches", pairs_sent,
             iou_sb.checked, iou_sb.errors);
    $display("results: %0d overlap (%0d at 1.0), %0d disjoint, %0d empty union",
             iou_sb.n_overlap, iou_sb.n_full, iou_sb.n_disjoint, iou_sb.n_empty);
    if (iou_sb.errors == 0 && iou_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
